// ----- hdl/tcc_pkg.sv -----
package tcc_pkg;

  localparam int unsigned CURRENT_FULL_SCALE = 1023;
  localparam int unsigned CRUISE_MARGIN      = 8;
  localparam int unsigned LOCK_TICKS         = 80;

  // floor(y / 5) == (y * 6554) >> 15 for y below 16384
  localparam int unsigned DIV5_RECIP = 6554;
  localparam int unsigned DIV5_SHIFT = 15;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_ASSIST_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURRENT_FACTOR = 3'd1;
  localparam logic [IDX_W-1:0] REG_ASSIST_LEVEL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_MAX      = 3'd3;
  localparam logic [IDX_W-1:0] REG_THROTTLE_MIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_THROTTLE_MAX   = 3'd5;
  localparam logic [IDX_W-1:0] REG_ERROR_LOW      = 3'd6;
  localparam logic [IDX_W-1:0] REG_ERROR_HIGH     = 3'd7;

  localparam logic [8:0]  FACTOR_ONE    = 9'd256;
  localparam logic [2:0]  LEVEL_FULL    = 3'd5;
  localparam logic [15:0] SPEED_MAX_RST = 16'd1000;
  localparam logic [7:0]  THR_MIN_RST   = 8'd45;
  localparam logic [7:0]  THR_MAX_RST   = 8'd180;
  localparam logic [7:0]  ERR_LOW_RST   = 8'd20;
  localparam logic [7:0]  ERR_HIGH_RST  = 8'd240;

  // serial divider: 24-bit numerator, 8-bit span, 16-bit quotient
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned DEN_W      = 8;
  localparam int unsigned DIV_RADIX  = 2;
  localparam int unsigned DIV_CYCLES = QUO_W / DIV_RADIX;
  localparam int unsigned DCNT_W     = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_FL,
    OP_CAP_MUL,
    OP_CAP_DIV5,
    OP_SELECT,
    OP_LOAD_CUR,
    OP_DIV,
    OP_STORE_CUR,
    OP_LOAD_SPD,
    OP_STORE_SPD,
    OP_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_NO_IN,
    ST_DIV,
    ST_OUT
  } stall_t;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_NO_DIV
  } br_t;

  localparam int unsigned PC_W = 4;

  localparam logic [PC_W-1:0] PC_ACCEPT    = 4'd0;
  localparam logic [PC_W-1:0] PC_FL        = 4'd1;
  localparam logic [PC_W-1:0] PC_CAP_MUL   = 4'd2;
  localparam logic [PC_W-1:0] PC_CAP_DIV5  = 4'd3;
  localparam logic [PC_W-1:0] PC_SELECT    = 4'd4;
  localparam logic [PC_W-1:0] PC_LOAD_CUR  = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV_CUR   = 4'd6;
  localparam logic [PC_W-1:0] PC_STORE_CUR = 4'd7;
  localparam logic [PC_W-1:0] PC_LOAD_SPD  = 4'd8;
  localparam logic [PC_W-1:0] PC_DIV_SPD   = 4'd9;
  localparam logic [PC_W-1:0] PC_STORE_SPD = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd11;

  typedef struct packed {
    uop_t            op;
    stall_t          stall;
    br_t             br;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, stall: ST_NONE, br: BR_ALWAYS, target: PC_ACCEPT};
    unique case (pc)
      PC_ACCEPT:    w = '{OP_ACCEPT,    ST_NO_IN, BR_NONE,   PC_ACCEPT};
      PC_FL:        w = '{OP_FL,        ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_CAP_MUL:   w = '{OP_CAP_MUL,   ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_CAP_DIV5:  w = '{OP_CAP_DIV5,  ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_SELECT:    w = '{OP_SELECT,    ST_NONE,  BR_NO_DIV, PC_EMIT};
      PC_LOAD_CUR:  w = '{OP_LOAD_CUR,  ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_DIV_CUR:   w = '{OP_DIV,       ST_DIV,   BR_NONE,   PC_ACCEPT};
      PC_STORE_CUR: w = '{OP_STORE_CUR, ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_LOAD_SPD:  w = '{OP_LOAD_SPD,  ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_DIV_SPD:   w = '{OP_DIV,       ST_DIV,   BR_NONE,   PC_ACCEPT};
      PC_STORE_SPD: w = '{OP_STORE_SPD, ST_NONE,  BR_NONE,   PC_ACCEPT};
      PC_EMIT:      w = '{OP_EMIT,      ST_OUT,   BR_ALWAYS, PC_ACCEPT};
      default:      w = '{OP_NOP,       ST_NONE,  BR_ALWAYS, PC_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/tcc_div.sv -----
module tcc_div
  import tcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] numerator,
  input  logic [DEN_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             last
);

  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;

  logic [DEN_W-1:0] rem_next;
  logic [QUO_W-1:0] quo_next;

  always_comb begin
    logic [DEN_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_next, quo_next[QUO_W-1]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        quo_next = {quo_next[QUO_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[QUO_W-2:0], 1'b0};
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // upper numerator bits stay below the divisor, so the quotient fits
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= numerator[NUM_W-1:QUO_W];
      quo <= numerator[QUO_W-1:0];
    end else if (ctl.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign last     = (cnt == DCNT_W'(DIV_CYCLES - 1));
  assign quotient = quo;

endmodule

// ----- hdl/throttle_cruise_controller.sv -----
// Each input transaction runs through microcode steps FL, CAP_MUL, CAP_DIV5,
// SELECT, then two runs of the 2-bit-per-cycle divider when the throttle map
// needs it (none in assist mode, with an empty span or throttle outside the
// span), then EMIT, which waits on a stalled output, before the next is taken.
// Synchronous reset: configuration registers to their documented values,
// cruise state following with zero reference, held output and hold count.
module throttle_cruise_controller
  import tcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       throttle_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             throttle_error,
  output logic [7:0]       effective_throttle,
  output logic [9:0]       current_target,
  output logic [15:0]      speed_target,
  output logic [1:0]       cruise_phase
);

  typedef enum logic [1:0] {
    CM_FOLLOW = 2'd0,
    CM_LOCKED = 2'd1,
    CM_ARMED  = 2'd2
  } cmode_t;

  localparam logic [7:0] MARGIN8  = 8'(CRUISE_MARGIN);
  localparam logic [8:0] MARGIN9  = 9'(CRUISE_MARGIN);
  localparam logic [6:0] LOCK7    = 7'(LOCK_TICKS);
  localparam logic [9:0] FSCALE   = 10'(CURRENT_FULL_SCALE);
  localparam logic [12:0] RECIP5  = 13'(DIV5_RECIP);

  // configuration
  logic        assist_mode;
  logic [8:0]  current_factor;
  logic [2:0]  assist_level;
  logic [15:0] speed_max;
  logic [7:0]  throttle_min;
  logic [7:0]  throttle_max;
  logic [7:0]  error_low;
  logic [7:0]  error_high;

  // cruise state
  cmode_t     mode;
  logic [7:0] cref;
  logic [7:0] held;
  logic [6:0] hold;

  cmode_t     mode_next;
  logic [7:0] cref_next;
  logic [7:0] held_next;
  logic [6:0] hold_next;

  // sequencer and datapath
  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            err;
  logic [10:0]     fl;
  logic [20:0]     prod;
  logic [9:0]      cap;
  logic [7:0]      diff;
  logic [9:0]      cur;
  logic [15:0]     spd;

  logic             in_fire;
  logic             out_busy;
  logic             need_div;
  logic             stall;
  logic             branch;
  div_ctl_t         dctl;
  logic [NUM_W-1:0] dnum;
  logic [QUO_W-1:0] quo;
  logic             dlast;
  logic [8:0]       f_sat;
  logic [2:0]       l_sat;
  logic [25:0]      div5_prod;
  logic             in_window;
  logic [6:0]       hold_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      assist_mode    <= 1'b0;
      current_factor <= FACTOR_ONE;
      assist_level   <= LEVEL_FULL;
      speed_max      <= SPEED_MAX_RST;
      throttle_min   <= THR_MIN_RST;
      throttle_max   <= THR_MAX_RST;
      error_low      <= ERR_LOW_RST;
      error_high     <= ERR_HIGH_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ASSIST_MODE:    assist_mode    <= cfg_data[0];
        REG_CURRENT_FACTOR: current_factor <= cfg_data[8:0];
        REG_ASSIST_LEVEL:   assist_level   <= cfg_data[2:0];
        REG_SPEED_MAX:      speed_max      <= cfg_data[15:0];
        REG_THROTTLE_MIN:   throttle_min   <= cfg_data[7:0];
        REG_THROTTLE_MAX:   throttle_max   <= cfg_data[7:0];
        REG_ERROR_LOW:      error_low      <= cfg_data[7:0];
        REG_ERROR_HIGH:     error_high     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign uw       = ucode(pc);
  assign in_ready = (uw.op == OP_ACCEPT);
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  assign in_window = ({1'b0, throttle_sample} + MARGIN9 > {1'b0, cref}) &&
                     ({1'b0, throttle_sample} < {1'b0, cref} + MARGIN9);
  assign hold_inc  = hold + 7'd1;

  always_comb begin
    mode_next = mode;
    cref_next = cref;
    held_next = held;
    hold_next = hold;
    unique case (mode)
      CM_LOCKED: begin
        if (throttle_sample < MARGIN8) mode_next = CM_ARMED;
      end
      CM_ARMED: begin
        if (throttle_sample > MARGIN8) begin
          mode_next = CM_FOLLOW;
          held_next = throttle_sample;
        end
      end
      default: begin
        if (throttle_sample > MARGIN8 && in_window) begin
          hold_next = hold_inc;
          held_next = throttle_sample;
          if (hold_inc > LOCK7) begin
            mode_next = CM_LOCKED;
            hold_next = '0;
            cref_next = '0;
          end
        end else begin
          hold_next = '0;
          cref_next = throttle_sample;
          held_next = throttle_sample;
        end
      end
    endcase
  end

  assign f_sat = (current_factor > FACTOR_ONE) ? FACTOR_ONE : current_factor;
  assign l_sat = (assist_level > LEVEL_FULL) ? LEVEL_FULL : assist_level;
  assign div5_prod = prod[20:8] * RECIP5;

  assign need_div = !assist_mode && (throttle_max > throttle_min) &&
                    (held > throttle_min) && (held < throttle_max);

  always_comb begin
    stall = 1'b0;
    unique case (uw.stall)
      ST_NO_IN: stall = !in_fire;
      ST_DIV:   stall = !dlast;
      ST_OUT:   stall = out_busy;
      default:  stall = 1'b0;
    endcase
    branch = 1'b0;
    unique case (uw.br)
      BR_ALWAYS: branch = 1'b1;
      BR_NO_DIV: branch = !need_div;
      default:   branch = 1'b0;
    endcase
  end

  always_comb begin
    dctl.load = (uw.op == OP_LOAD_CUR) || (uw.op == OP_LOAD_SPD);
    dctl.step = (uw.op == OP_DIV);
    dnum      = (uw.op == OP_LOAD_CUR) ? NUM_W'(diff) * NUM_W'(cap)
                                       : NUM_W'(diff) * NUM_W'(spd);
  end

  tcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dctl),
    .numerator (dnum),
    .divisor   (throttle_max - throttle_min),
    .quotient  (quo),
    .last      (dlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_ACCEPT;
      mode      <= CM_FOLLOW;
      cref      <= '0;
      held      <= '0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!stall) begin
        pc <= branch ? uw.target : pc + 1'b1;
      end
      if (in_fire) begin
        mode <= mode_next;
        cref <= cref_next;
        held <= held_next;
        hold <= hold_next;
      end
      if (uw.op == OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_ACCEPT: begin
        err <= (throttle_sample < error_low) || (throttle_sample > error_high);
      end
      OP_FL:       fl   <= 11'(f_sat) * 11'(l_sat);
      OP_CAP_MUL:  prod <= fl * FSCALE;
      OP_CAP_DIV5: cap  <= div5_prod[DIV5_SHIFT+9:DIV5_SHIFT];
      OP_SELECT: begin
        diff <= held - throttle_min;
        if (assist_mode) begin
          cur <= cap;
          spd <= speed_max;
        end else if (throttle_max <= throttle_min || held <= throttle_min) begin
          cur <= '0;
          spd <= '0;
        end else begin
          cur <= cap;
          spd <= speed_max;
        end
      end
      OP_STORE_CUR: cur <= quo[9:0];
      OP_STORE_SPD: spd <= quo;
      OP_EMIT: begin
        if (!out_busy) begin
          throttle_error     <= err;
          effective_throttle <= held;
          current_target     <= cur;
          speed_target       <= spd;
          cruise_phase       <= mode;
        end
      end
      default: ;
    endcase
  end

endmodule
